### rtl/core/fltt_pkg.sv
package fltt_pkg;
	localparam int SetsDefault = 1024;
	localparam int WaysDefault = 4;
	localparam int QueueDepth = 2;
	localparam logic [15:0] EtherIpv4 = 16'h0800;
	localparam logic [7:0] ProtoTcp = 8'd6;
	localparam logic [7:0] ProtoUdp = 8'd17;
	localparam logic [63:0] StaleLimitReset = 64'd5000000000;
	localparam logic FuncIngress = 1'b0;
	localparam logic FuncEgress = 1'b1;

	typedef struct packed {
		logic [31:0] sa;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  pr;
	} key_t;

	typedef struct packed {
		logic        func;
		key_t        key;
		logic [63:0] t;
	} req_t;

	function automatic logic [31:0] hash32(key_t k);
		logic [31:0] x;
		logic [31:0] m;
		m = 32'(k.pr) * 32'h9e3779b9;
		x = k.sa ^ {k.da[15:0], k.da[31:16]} ^ {k.sp, k.dp} ^ m;
		x = x ^ (x >> 16);
		return x;
	endfunction
endpackage

### rtl/core/flow_latency_timestamp_table_unit.sv
// Flow round-trip latency table. Ingress packets store their time under the flow key in a
// Sets x Ways LRU table (Sets a power of two); egress packets look up the reversed key and,
// on a hit within stale_limit_ns, return one latency record. The front checks and queues
// packets (2 deep) and drops malformed ones on accept; the back takes one packet at a time
// through hash, multiply, set read and update, and waits while a delivered record is
// stalled. After reset a pass over all Sets sets clears the valid bits and LRU state before
// packets are processed.
module flow_latency_timestamp_table_unit import fltt_pkg::*; #(
	parameter int Sets = SetsDefault,
	parameter int Ways = WaysDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] pkt_len,
	input  logic [15:0] ether_type,
	input  logic [3:0]  ip_header_words,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [63:0] time_ns,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] req_src_addr,
	output logic [31:0] req_dst_addr,
	output logic [15:0] req_src_port,
	output logic [15:0] req_dst_port,
	output logic [7:0]  req_proto,
	output logic [63:0] rtt_ns,
	output logic [63:0] arrival_ns,
	output logic [63:0] depart_ns
);
	logic [63:0] limit_q;
	logic q_valid, q_pop;
	req_t q_data;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= StaleLimitReset;
		else if (cfg_valid) limit_q <= cfg_data;
	end

	fltt_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .func, .pkt_len, .ether_type,
		.ip_header_words, .ip_proto, .src_addr, .dst_addr, .src_port, .dst_port,
		.time_ns, .q_valid, .q_data, .q_pop
	);

	fltt_back #(.Sets(Sets), .Ways(Ways)) u_back (
		.clk, .arst_n, .q_valid, .q_data, .q_pop, .limit(limit_q), .out_valid,
		.out_stall, .req_src_addr, .req_dst_addr, .req_src_port, .req_dst_port,
		.req_proto, .rtt_ns, .arrival_ns, .depart_ns
	);
endmodule

### rtl/core/fltt_front.sv
module fltt_front import fltt_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] pkt_len,
	input  logic [15:0] ether_type,
	input  logic [3:0]  ip_header_words,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [63:0] time_ns,
	output logic        q_valid,
	output req_t        q_data,
	input  logic        q_pop
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	req_t            fifo_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            ok;
	logic [5:0]      thl;
	logic [16:0]     need;
	req_t            r;
	logic            push;

	always_comb begin
		thl = (ip_proto == ProtoTcp) ? 6'd20 : 6'd8;
		need = 17'd14 + {11'd0, ip_header_words, 2'b00} + {11'd0, thl};
		ok = ether_type == EtherIpv4 && pkt_len >= 16'd34 &&
			(ip_proto == ProtoTcp || ip_proto == ProtoUdp) && need <= {1'b0, pkt_len};
		r.func = func;
		r.t = time_ns;
		if (func == FuncEgress)
			r.key = '{sa: dst_addr, da: src_addr, sp: dst_port, dp: src_port, pr: ip_proto};
		else
			r.key = '{sa: src_addr, da: dst_addr, sp: src_port, dp: dst_port, pr: ip_proto};
	end

	assign in_stall = cnt_q == (AW+1)'(Depth);
	assign push = in_valid && !in_stall && ok;
	assign q_valid = cnt_q != '0;
	assign q_data = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (q_pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

`ifndef SYNTH
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth)) else $error("count");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push");
`endif
endmodule

### rtl/core/fltt_back.sv
module fltt_back import fltt_pkg::*; #(
	parameter int Sets = SetsDefault,
	parameter int Ways = WaysDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  req_t        q_data,
	output logic        q_pop,
	input  logic [63:0] limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] req_src_addr,
	output logic [31:0] req_dst_addr,
	output logic [15:0] req_src_port,
	output logic [15:0] req_dst_port,
	output logic [7:0]  req_proto,
	output logic [63:0] rtt_ns,
	output logic [63:0] arrival_ns,
	output logic [63:0] depart_ns
);
	localparam int SW = (Sets > 1) ? $clog2(Sets) : 1;
	localparam int WW = (Ways > 1) ? $clog2(Ways) : 1;
	localparam int LW = Ways * WW;

	typedef enum logic [2:0] {S_IDLE, S_HASH, S_MIX, S_READ, S_DO, S_OUT, S_CLR} st_t;
	st_t st_q;

	key_t [Ways-1:0]       key_mem [Sets];
	logic [Ways-1:0][63:0] time_mem [Sets];
	logic [Ways-1:0]       val_mem [Sets];
	logic [LW-1:0]         lru_mem [Sets];

	req_t        req_q;
	logic [31:0] h_q, x_q;
	logic [SW-1:0] set_q;
	key_t [Ways-1:0] rk_q;
	logic [Ways-1:0][63:0] rt_q;
	logic [Ways-1:0] rv_q;
	logic [LW-1:0] lru_q;
	logic [SW:0] clr_q;

	logic [31:0] mixed;
	logic [WW-1:0] hitw, freew, vw, pos;
	logic        anyhit, anyfree;
	logic [LW-1:0] lru_n, lru_init;
	key_t [Ways-1:0] key_n;
	logic [Ways-1:0][63:0] time_n;
	logic [Ways-1:0] val_n;
	logic [63:0] rtt;

	always_comb begin
		mixed = x_q ^ (x_q >> 16);
		anyhit = 1'b0; hitw = '0; anyfree = 1'b0; freew = '0;
		for (int w = Ways-1; w >= 0; w--) begin
			if (rv_q[w] && rk_q[w] == req_q.key) begin anyhit = 1'b1; hitw = WW'(w); end
			if (!rv_q[w]) begin anyfree = 1'b1; freew = WW'(w); end
		end
		vw = anyhit ? hitw : (anyfree ? freew : lru_q[WW-1:0]);
		pos = '0;
		for (int i = 0; i < Ways; i++)
			if (lru_q[i*WW +: WW] == vw) pos = WW'(i);
		for (int i = 0; i < Ways; i++) begin
			if (i == Ways-1) lru_n[i*WW +: WW] = vw;
			else if (WW'(i) >= pos) lru_n[i*WW +: WW] = lru_q[(i+1)*WW +: WW];
			else lru_n[i*WW +: WW] = lru_q[i*WW +: WW];
		end
		for (int i = 0; i < Ways; i++)
			lru_init[i*WW +: WW] = WW'(i);
		key_n = rk_q;
		key_n[vw] = req_q.key;
		time_n = rt_q;
		time_n[vw] = req_q.t;
		val_n = rv_q;
		if (req_q.func == FuncIngress) val_n[vw] = 1'b1;
		else val_n[hitw] = 1'b0;
		rtt = req_q.t - rt_q[hitw];
	end

	assign q_pop = st_q == S_IDLE && q_valid;
	assign out_valid = st_q == S_OUT;

	always_ff @(posedge clk) begin
		if (st_q == S_READ) begin
			rk_q <= key_mem[set_q];
			rt_q <= time_mem[set_q];
			rv_q <= val_mem[set_q];
			lru_q <= lru_mem[set_q];
		end
		if (st_q == S_DO) begin
			if (req_q.func == FuncIngress) begin
				key_mem[set_q] <= key_n;
				time_mem[set_q] <= time_n;
				lru_mem[set_q] <= lru_n;
			end
			if (req_q.func == FuncIngress || anyhit) val_mem[set_q] <= val_n;
		end
		if (st_q == S_CLR) begin
			val_mem[clr_q[SW-1:0]] <= '0;
			lru_mem[clr_q[SW-1:0]] <= lru_init;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			req_q <= '0;
			h_q <= '0;
			x_q <= '0;
			set_q <= '0;
			req_src_addr <= '0;
			req_dst_addr <= '0;
			req_src_port <= '0;
			req_dst_port <= '0;
			req_proto <= '0;
			arrival_ns <= '0;
			depart_ns <= '0;
			rtt_ns <= '0;
		end else begin
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SW+1)'(Sets-1)) st_q <= S_IDLE;
				end
				S_IDLE: if (q_valid) begin
					req_q <= q_data;
					h_q <= hash32(q_data.key);
					st_q <= S_HASH;
				end
				S_HASH: begin
					x_q <= h_q * 32'h045d9f3b;
					st_q <= S_MIX;
				end
				S_MIX: begin
					set_q <= SW'(mixed & 32'(Sets - 1));
					st_q <= S_READ;
				end
				S_READ: st_q <= S_DO;
				S_DO: begin
					if (req_q.func == FuncIngress) begin
						st_q <= S_IDLE;
					end else if (anyhit) begin
						req_src_addr <= rk_q[hitw].sa;
						req_dst_addr <= rk_q[hitw].da;
						req_src_port <= rk_q[hitw].sp;
						req_dst_port <= rk_q[hitw].dp;
						req_proto <= rk_q[hitw].pr;
						arrival_ns <= rt_q[hitw];
						depart_ns <= req_q.t;
						rtt_ns <= rtt;
						st_q <= (rtt > limit) ? S_IDLE : S_OUT;
					end else st_q <= S_IDLE;
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == S_HASH) else $error("pop");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rtt_ns)) else $error("hold");
	a_out_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rtt_ns <= limit) else $error("stale out");
`endif
endmodule

### verif/tb_flow_latency_timestamp_table_unit.sv
module tb_flow_latency_timestamp_table_unit import fltt_pkg::*; ();

	localparam int SETS = SetsDefault;
	localparam int WAYS = WaysDefault;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		key_t        key;
		logic [63:0] rtt;
		logic [63:0] arrival;
		logic [63:0] depart;
	} latency_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        func = FuncIngress;
	logic [15:0] pkt_len = '0;
	logic [15:0] ether_type = '0;
	logic [3:0]  ip_header_words = '0;
	logic [7:0]  ip_proto = '0;
	logic [31:0] src_addr = '0;
	logic [31:0] dst_addr = '0;
	logic [15:0] src_port = '0;
	logic [15:0] dst_port = '0;
	logic [63:0] time_ns = '0;
	logic        out_stall = 1'b0;
	logic        cfg_ready, in_stall, out_valid;
	logic [31:0] req_src_addr, req_dst_addr;
	logic [15:0] req_src_port, req_dst_port;
	logic [7:0]  req_proto;
	logic [63:0] rtt_ns, arrival_ns, depart_ns;

	flow_latency_timestamp_table_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .pkt_len(pkt_len),
		.ether_type(ether_type), .ip_header_words(ip_header_words), .ip_proto(ip_proto),
		.src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port),
		.dst_port(dst_port), .time_ns(time_ns),
		.out_valid(out_valid), .out_stall(out_stall),
		.req_src_addr(req_src_addr), .req_dst_addr(req_dst_addr),
		.req_src_port(req_src_port), .req_dst_port(req_dst_port), .req_proto(req_proto),
		.rtt_ns(rtt_ns), .arrival_ns(arrival_ns), .depart_ns(depart_ns)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// table mirror
	key_t        way_key[SETS][WAYS];
	logic [63:0] flow_time[SETS][WAYS];
	bit          flow_live[SETS][WAYS];
	int          lru_order[SETS][WAYS];
	logic [63:0] stale_limit = StaleLimitReset;

	latency_rec_t latency_q[$];
	int mismatches = 0;
	int packets_sent = 0;
	int records_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	logic [63:0] now_ns;
	key_t flow_pool[64];

	function automatic int set_index(key_t k);
		logic [31:0] x;
		x = k.sa ^ {k.da[15:0], k.da[31:16]} ^ {k.sp, k.dp} ^ (32'(k.pr) * 32'h9e3779b9);
		x = x ^ (x >> 16);
		x = x * 32'h045d9f3b;
		x = x ^ (x >> 16);
		return int'(x % SETS);
	endfunction

	function automatic key_t random_key();
		key_t k;
		k.sa = $urandom;
		k.da = $urandom;
		k.sp = $urandom;
		k.dp = $urandom;
		k.pr = ($urandom_range(0, 1) != 0) ? ProtoTcp : ProtoUdp;
		return k;
	endfunction

	function automatic key_t key_in_set(int s);
		key_t k;
		k = random_key();
		while (set_index(k) != s)
			k = random_key();
		return k;
	endfunction

	function automatic void promote_way(int s, int w);
		int pos;
		pos = 0;
		for (int i = 0; i < WAYS; i++)
			if (lru_order[s][i] == w)
				pos = i;
		for (int i = pos; i < WAYS - 1; i++)
			lru_order[s][i] = lru_order[s][i + 1];
		lru_order[s][WAYS - 1] = w;
	endfunction

	function automatic void predict_packet(logic fn, logic [15:0] len, logic [15:0] et,
			logic [3:0] ihl, key_t k, logic [63:0] t);
		int thl, s, w;
		key_t lk;
		latency_rec_t rec;
		if (len < 34 || et != EtherIpv4)
			return;
		if (k.pr != ProtoTcp && k.pr != ProtoUdp)
			return;
		thl = (k.pr == ProtoTcp) ? 20 : 8;
		if (14 + 4 * int'(ihl) + thl > int'(len))
			return;
		if (fn == FuncIngress) begin
			s = set_index(k);
			w = -1;
			for (int i = 0; i < WAYS; i++)
				if (w < 0 && flow_live[s][i] && way_key[s][i] == k)
					w = i;
			if (w < 0) begin
				for (int i = 0; i < WAYS; i++)
					if (w < 0 && !flow_live[s][i])
						w = i;
				if (w < 0)
					w = lru_order[s][0];
				way_key[s][w] = k;
				flow_live[s][w] = 1'b1;
			end
			flow_time[s][w] = t;
			promote_way(s, w);
			return;
		end
		lk = '{sa: k.da, da: k.sa, sp: k.dp, dp: k.sp, pr: k.pr};
		s = set_index(lk);
		w = -1;
		for (int i = 0; i < WAYS; i++)
			if (w < 0 && flow_live[s][i] && way_key[s][i] == lk)
				w = i;
		if (w < 0)
			return;
		flow_live[s][w] = 1'b0;
		rec.key = lk;
		rec.arrival = flow_time[s][w];
		rec.rtt = t - rec.arrival;
		rec.depart = t;
		if (rec.rtt <= stale_limit)
			latency_q.push_back(rec);
	endfunction

	task automatic send_raw(logic fn, logic [15:0] len, logic [15:0] et, logic [3:0] ihl,
			key_t k, logic [63:0] t);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = fn;
		pkt_len = len;
		ether_type = et;
		ip_header_words = ihl;
		ip_proto = k.pr;
		src_addr = k.sa;
		dst_addr = k.da;
		src_port = k.sp;
		dst_port = k.dp;
		time_ns = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_packet(fn, len, et, ihl, k, t);
		packets_sent++;
	endtask

	// well-formed packet; egress carries the reversed key of flow k
	task automatic send_flow(logic fn, key_t k, logic [63:0] t);
		int ihl, need;
		key_t pk;
		logic [15:0] len;
		ihl = $urandom_range(0, 15);
		need = 14 + 4 * ihl + ((k.pr == ProtoTcp) ? 20 : 8);
		if (need < 34)
			need = 34;
		len = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'(need + $urandom_range(0, 40));
		pk = k;
		if (fn == FuncEgress)
			pk = '{sa: k.da, da: k.sa, sp: k.dp, dp: k.sp, pr: k.pr};
		send_raw(fn, len, EtherIpv4, 4'(ihl), pk, t);
	endtask

	task automatic send_noise();
		key_t k;
		k = random_key();
		k.pr = ($urandom_range(0, 2) == 0) ? 8'($urandom) : k.pr;
		send_raw(1'($urandom), 16'($urandom),
			($urandom_range(0, 1) != 0) ? EtherIpv4 : 16'($urandom),
			4'($urandom), k, {$urandom, $urandom});
	endtask

	task automatic idle_inputs();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drain();
		idle_inputs();
		while (latency_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_stale_limit(logic [63:0] v);
		wait_drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		stale_limit = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		latency_rec_t rec;
		if (arst_n && out_valid && !out_stall) begin
			records_seen++;
			if (latency_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected latency record, rtt %h", rtt_ns);
			end else begin
				rec = latency_q.pop_front();
				check_field("req_src_addr", 64'(rec.key.sa), 64'(req_src_addr));
				check_field("req_dst_addr", 64'(rec.key.da), 64'(req_dst_addr));
				check_field("req_src_port", 64'(rec.key.sp), 64'(req_src_port));
				check_field("req_dst_port", 64'(rec.key.dp), 64'(req_dst_port));
				check_field("req_proto", 64'(rec.key.pr), 64'(req_proto));
				check_field("rtt_ns", rec.rtt, rtt_ns);
				check_field("arrival_ns", rec.arrival, arrival_ns);
				check_field("depart_ns", rec.depart, depart_ns);
			end
		end
	end

	task automatic test_directed();
		key_t k, ev[6];
		int s;
		k = '{sa: 32'hffffffff, da: 32'h0, sp: 16'hffff, dp: 16'h0, pr: ProtoTcp};
		send_raw(FuncIngress, 16'd54, EtherIpv4, 4'd5, k, 64'hffff_ffff_ffff_fff0);
		// wrap of the elapsed time
		send_flow(FuncEgress, k, 64'h20);
		send_flow(FuncEgress, k, 64'h30);
		k = '{sa: 32'h0, da: 32'hffffffff, sp: 16'h0, dp: 16'hffff, pr: ProtoUdp};
		send_raw(FuncIngress, 16'd42, EtherIpv4, 4'd5, k, 64'd1000);
		send_raw(FuncIngress, 16'd42, EtherIpv4, 4'd5, k, 64'd2000);
		send_flow(FuncEgress, k, 64'd2500);
		send_flow(FuncIngress, k, 64'd0);
		send_flow(FuncEgress, k, StaleLimitReset + 1);
		send_flow(FuncIngress, k, 64'd0);
		send_flow(FuncEgress, k, StaleLimitReset);
		// rejected packets: bad type, bad protocol, short, options beyond length; then an egress miss
		send_raw(FuncIngress, 16'd54, 16'h86dd, 4'd5, k, 64'd1);
		send_raw(FuncIngress, 16'd54, EtherIpv4, 4'd5, '{k.sa, k.da, k.sp, k.dp, 8'd1}, 64'd1);
		send_raw(FuncIngress, 16'd33, EtherIpv4, 4'd0, k, 64'd1);
		send_raw(FuncIngress, 16'd81, EtherIpv4, 4'd15, k, 64'd1);
		send_raw(FuncEgress, 16'd54, EtherIpv4, 4'd5, k, 64'd1);
		// small header length only shortens the transport check
		send_raw(FuncIngress, 16'd34, EtherIpv4, 4'd0, k, 64'd7);
		send_raw(FuncEgress, 16'hffff, EtherIpv4, 4'd15,
			'{sa: k.da, da: k.sa, sp: k.dp, dp: k.sp, pr: k.pr}, 64'd9);
		// overflow one set to force eviction of the oldest way
		s = $urandom_range(0, SETS - 1);
		for (int i = 0; i < 6; i++) begin
			ev[i] = key_in_set(s);
			send_flow(FuncIngress, ev[i], 64'(100 + i));
		end
		send_flow(FuncIngress, ev[2], 64'd200);
		for (int i = 0; i < 6; i++)
			send_flow(FuncEgress, ev[i], 64'd300);
		wait_drain();
	endtask

	task automatic test_random(int n, int idle_pct, int stall_pct);
		key_t k;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			now_ns += $urandom_range(0, 5000);
			k = flow_pool[$urandom_range(0, 63)];
			case ($urandom_range(0, 9))
				0, 1: send_noise();
				2, 3, 4, 5: send_flow(FuncIngress, k, now_ns);
				6: send_flow(FuncEgress, k, {$urandom, $urandom});
				default: send_flow(FuncEgress, k, now_ns + $urandom_range(0, 2000000));
			endcase
		end
		wait_drain();
	endtask

	task automatic test_stale_limits();
		logic [63:0] limits[4];
		limits = '{64'd0, 64'hffff_ffff_ffff_ffff, 64'd1500, StaleLimitReset};
		foreach (limits[i]) begin
			write_stale_limit(limits[i]);
			test_random(50, 30, 30);
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_cycles = 400;
		for (int i = 0; i < 20; i++)
			send_flow(FuncIngress, flow_pool[i], now_ns);
		for (int i = 0; i < 20; i++)
			send_flow(FuncEgress, flow_pool[i], now_ns + 64'(i));
		wait_drain();
	endtask

	initial begin
		for (int s = 0; s < SETS; s++)
			for (int w = 0; w < WAYS; w++) begin
				flow_live[s][w] = 1'b0;
				lru_order[s][w] = w;
			end
		now_ns = {$urandom, $urandom};
		for (int i = 0; i < 48; i++)
			flow_pool[i] = random_key();
		for (int i = 48; i < 64; i++)
			flow_pool[i] = key_in_set(i < 56 ? 3 : 777);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(150, 0, 0);
		test_random(150, 82, 0);
		test_random(150, 0, 82);
		test_random(150, 27, 27);
		test_stale_limits();
		test_backpressure();
		wait_drain();
		$display("%0d packets sent, %0d latency records checked", packets_sent, records_seen);
		$display("covered rejects, eviction, stale drops, time wrap and limits 0 to max");
		if (mismatches == 0 && latency_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end
endmodule
